/* design/assert_macros.svh */
// Assertion macros for the checker file of the keyed count table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising edge of clk, switched off while rst_n is low.
`define KCT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check on the rising edge of clk that also holds during reset.
`define KCT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/kct_pkg.sv */
// Types, constants and command structs shared by the keyed count table modules.
package kct_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int KEY_W      = 16;
  localparam int COUNT_W    = 16;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef logic [SLOT_IDX_W-1:0] slot_idx_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [KEY_W-1:0]   item_key;
    logic [COUNT_W-1:0] amount;
  } kct_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] current_count;
    logic               present;
    logic               table_full;
    logic               count_saturated;
  } kct_out_t;

  typedef struct packed {
    logic load_item;
    logic lookup;
    logic update;
  } kct_cmd_t;

  typedef struct packed {
    logic out_free;
  } kct_status_t;

endpackage

/* design/kct_ctrl.sv */
// Controller state machine of the keyed count table: accept, look up, update.
module kct_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  kct_pkg::kct_status_t status,
  output kct_pkg::kct_cmd_t    cmd
);
  import kct_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd.lookup = 1'b1;
        state_nxt  = ST_UPD;
      end
      ST_UPD: begin
        if (status.out_free) begin
          cmd.update = 1'b1;
          in_ready   = 1'b1;
          if (in_valid) begin
            cmd.load_item = 1'b1;
            state_nxt     = ST_LOOK;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* design/kct_dpath.sv */
// Datapath of the keyed count table: slot keys, count memory and result register.
module kct_dpath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  kct_pkg::kct_cmd_t    cmd,
  output kct_pkg::kct_status_t status,
  input  kct_pkg::kct_in_t     in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output kct_pkg::kct_out_t    out_data
);
  import kct_pkg::*;

  kct_in_t            item_r;
  logic [SLOT_COUNT-1:0] used_r;
  logic [SLOT_COUNT-1:0] used_nxt;
  logic [KEY_W-1:0]   keys_r [SLOT_COUNT];
  logic [COUNT_W-1:0] counts_mem [SLOT_COUNT];

  logic [SLOT_COUNT-1:0] match;
  logic               hit;
  slot_idx_t          hit_idx;
  logic               free_any;
  slot_idx_t          free_idx;

  logic               hit_r;
  slot_idx_t          hit_idx_r;
  logic               free_r;
  slot_idx_t          free_idx_r;
  logic [COUNT_W-1:0] rd_data_r;

  logic               wr_en;
  slot_idx_t          wr_addr;
  logic [COUNT_W-1:0] wr_data;
  logic               key_wr;
  kct_out_t           res;
  logic [COUNT_W:0]   sum;

  kct_out_t           out_r;
  logic               out_valid_r;

  // Keys are unique among used slots, so the match vector is one-hot and
  // the index is an OR of the matching positions.
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      match[i] = used_r[i] && (keys_r[i] == item_r.item_key);
      hit      = hit | match[i];
      hit_idx  = hit_idx | (match[i] ? slot_idx_t'(i) : '0);
    end
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_any = 1'b1;
        free_idx = slot_idx_t'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
    if (cmd.lookup) begin
      hit_r      <= hit;
      hit_idx_r  <= hit_idx;
      free_r     <= free_any;
      free_idx_r <= free_idx;
      rd_data_r  <= counts_mem[hit_idx];
    end
  end

  always_comb begin
    res      = '0;
    wr_en    = 1'b0;
    wr_addr  = hit_idx_r;
    wr_data  = '0;
    key_wr   = 1'b0;
    used_nxt = used_r;
    sum      = {1'b0, rd_data_r} + {1'b0, item_r.amount};
    if (item_r.item_key != '0) begin
      case (item_r.operation)
        OP_ADD: begin
          if (hit_r) begin
            wr_en = 1'b1;
            if (sum[COUNT_W]) begin
              wr_data             = COUNT_MAX;
              res.count_saturated = 1'b1;
            end else begin
              wr_data = sum[COUNT_W-1:0];
            end
            res.current_count = wr_data;
          end else if (free_r) begin
            wr_en                = 1'b1;
            wr_addr              = free_idx_r;
            wr_data              = item_r.amount;
            key_wr               = 1'b1;
            used_nxt[free_idx_r] = 1'b1;
            res.current_count    = item_r.amount;
          end else begin
            res.table_full = 1'b1;
          end
        end
        OP_REMOVE: begin
          if (hit_r) begin
            wr_en = 1'b1;
            if (rd_data_r <= item_r.amount) begin
              used_nxt[hit_idx_r] = 1'b0;
            end else begin
              wr_data = rd_data_r - item_r.amount;
            end
            res.current_count = wr_data;
          end
        end
        default: begin
          if (hit_r) begin
            res.current_count = rd_data_r;
          end
        end
      endcase
    end
    res.present = (res.current_count != '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.update && wr_en) begin
      counts_mem[wr_addr] <= wr_data;
    end
    if (cmd.update && key_wr) begin
      keys_r[free_idx_r] <= item_r.item_key;
    end
    if (cmd.update) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.update) begin
        used_r      <= used_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.out_free = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_data        = out_r;

endmodule

/* design/keyed_count_table_core.sv */
// A result beat passes the item register, the look-up registers and the result
// register. The next beat is accepted in the single-slot update of the previous
// one, after its key look-up (compare across all slots and count memory read).
// Reset: rst_n, synchronous and active low, frees every slot at once through
// per-slot used flags; there is no clearing pass and no beat is held off.
module keyed_count_table_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  kct_pkg::kct_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output kct_pkg::kct_out_t out_data
);
  import kct_pkg::*;

  // The controller sequences each beat through three steps: the item is
  // captured on acceptance, the look-up cycle compares the key against every
  // used slot and reads the count memory at the matching slot, and the
  // update cycle writes the new count and key and loads the result register.
  kct_cmd_t    cmd;
  kct_status_t status;

  kct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the slot keys in flip-flops so that all of them are
  // compared in parallel; counts live in a memory with a registered read.
  // The result register lets the next beat be accepted while the previous
  // result still waits for the consumer; the update stalls only when that
  // register is occupied and not being drained.
  kct_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* design/kct_checker.sv */
// Port-level checker for the keyed count table and its bind to the top level.
`include "assert_macros.svh"

module kct_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input kct_pkg::kct_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input kct_pkg::kct_out_t out_data
);

  logic in_stall;
  logic out_stall;
  logic out_full;
  logic count_nz;

  assign in_stall  = in_valid && !in_ready;
  assign out_stall = out_valid && !out_ready;
  assign out_full  = out_valid && out_data.table_full;
  assign count_nz  = (out_data.current_count != 16'd0);

  `KCT_ASSERT(a_in_hold, in_stall |=> in_valid && $stable(in_data), "input beat moved")
  `KCT_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(out_data), "result moved")
  `KCT_ASSERT(a_present, out_valid |-> out_data.present == count_nz, "present flag wrong")
  `KCT_ASSERT(a_full_empty, out_full |-> !count_nz && !out_data.count_saturated, "bad full beat")
  `KCT_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result valid straight after reset")

endmodule

bind keyed_count_table_core kct_checker u_kct_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* tb/tb.sv */
// Self-checking testbench for keyed_count_table_core with a predicting scoreboard.
`timescale 1ns / 1ps

module tb;
  import kct_pkg::*;

  // Operation code three has no name in the package; the block treats it as a query.
  localparam logic [1:0] OP_SPARE       = 2'd3;
  localparam int         RESET_CYCLES   = 7;
  localparam int         WATCHDOG_LIMIT = 1000;
  localparam int         DRAIN_CYCLES   = 8;
  localparam int         POOL_DEPTH     = 100;
  localparam int         PHASE_COUNT    = 5;
  localparam int         PHASE_BEATS    = 110;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_PATTERN
  } ready_mode_t;

  // Mirrors the slot table and queues the result each accepted beat should give.
  class count_table_scoreboard;
    logic [KEY_W-1:0]   slot_key [SLOT_COUNT];
    logic [COUNT_W-1:0] slot_cnt [SLOT_COUNT];
    kct_out_t           expected_q [$];
    int unsigned        errors;

    function new();
      foreach (slot_key[i]) begin
        slot_key[i] = '0;
        slot_cnt[i] = '0;
      end
      errors = 0;
    endfunction

    function void note_input(kct_in_t beat);
      kct_out_t         res;
      int               hit;
      int               free_slot;
      logic [COUNT_W:0] sum;
      res       = '0;
      hit       = -1;
      free_slot = -1;
      if (beat.item_key != '0) begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (hit < 0 && slot_key[i] == beat.item_key) hit = i;
          if (free_slot < 0 && slot_key[i] == '0) free_slot = i;
        end
        case (beat.operation)
          OP_ADD: begin
            if (hit >= 0) begin
              sum = {1'b0, slot_cnt[hit]} + {1'b0, beat.amount};
              if (sum[COUNT_W]) begin
                slot_cnt[hit]       = COUNT_MAX;
                res.count_saturated = 1'b1;
              end else begin
                slot_cnt[hit] = sum[COUNT_W-1:0];
              end
              res.current_count = slot_cnt[hit];
            end else if (free_slot >= 0) begin
              // A fresh key takes the lowest free slot, even with an amount of zero.
              slot_key[free_slot] = beat.item_key;
              slot_cnt[free_slot] = beat.amount;
              res.current_count   = beat.amount;
            end else begin
              res.table_full = 1'b1;
            end
          end
          OP_REMOVE: begin
            if (hit >= 0) begin
              if (slot_cnt[hit] <= beat.amount) begin
                slot_key[hit] = '0;
                slot_cnt[hit] = '0;
              end else begin
                slot_cnt[hit]     = slot_cnt[hit] - beat.amount;
                res.current_count = slot_cnt[hit];
              end
            end
          end
          default: begin
            if (hit >= 0) res.current_count = slot_cnt[hit];
          end
        endcase
      end
      res.present = (res.current_count != '0);
      expected_q.push_back(res);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(kct_out_t got);
      kct_out_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual %p", $time, got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        compare_field("current_count", want.current_count, got.current_count);
        compare_field("present", want.present, got.present);
        compare_field("table_full", want.table_full, got.table_full);
        compare_field("count_saturated", want.count_saturated, got.count_saturated);
      end
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  kct_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  kct_out_t out_data;

  count_table_scoreboard count_sb;
  logic [KEY_W-1:0]      key_pool [POOL_DEPTH];
  int                    burst_left = 0;
  int unsigned           idle_cycles = 0;
  ready_mode_t           ready_mode = READY_ALWAYS;
  logic [15:0]           ready_cycle = '0;
  logic [7:0]            stall_pattern = 8'hFF;

  keyed_count_table_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Both channels are sampled here, before any of this edge's updates land.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) count_sb.note_input(in_data);
      if (out_valid && out_ready) count_sb.check_result(out_data);
    end
  end

  // The receiver changes its stall habit whenever the low byte of its cycle counter wraps.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready   <= 1'b0;
      ready_cycle <= '0;
    end else begin
      ready_cycle <= ready_cycle + 16'd1;
      if (ready_cycle[7:0] == 8'd0) begin
        ready_mode    <= ready_mode_t'($urandom_range(0, 3));
        stall_pattern <= 8'($urandom()) | 8'h01;
      end
      case (ready_mode)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
        READY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:      out_ready <= stall_pattern[ready_cycle[2:0]];
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
        $display("keyed_count_table_core: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic kct_in_t mk_beat(logic [1:0] op, logic [KEY_W-1:0] key,
                                      logic [COUNT_W-1:0] amt);
    kct_in_t b;
    b.operation = op;
    b.item_key  = key;
    b.amount    = amt;
    return b;
  endfunction

  function automatic kct_in_t random_beat(int pool_size, int add_pct, int rem_pct);
    kct_in_t b;
    int      pick;
    pick = $urandom_range(0, 99);
    if (pick < add_pct) b.operation = OP_ADD;
    else if (pick < add_pct + rem_pct) b.operation = OP_REMOVE;
    else if (pick < 97) b.operation = OP_QUERY;
    else b.operation = OP_SPARE;
    b.item_key = ($urandom_range(0, 49) == 0) ? '0 : key_pool[$urandom_range(0, pool_size - 1)];
    case ($urandom_range(0, 9))
      0:       b.amount = '0;
      1:       b.amount = COUNT_MAX;
      2, 3:    b.amount = 16'($urandom_range(1, 4));
      4:       b.amount = 16'($urandom_range(16'hF000, 16'hFFFF));
      default: b.amount = 16'($urandom());
    endcase
    return b;
  endfunction

  // Holds the beat until it is taken; a new burst may open with a gap first.
  task automatic send_beat(kct_in_t beat);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    int pool_size;
    int add_pct;
    int rem_pct;
    count_sb = new();
    foreach (key_pool[i]) key_pool[i] = 16'($urandom_range(1, 65535));
    key_pool[0] = 16'hFFFF;
    key_pool[1] = 16'h0001;
    rst_n <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats: empty table, zero amounts, saturation, freeing and key zero.
    send_beat(mk_beat(OP_QUERY,  16'h0001, 16'h0000));
    send_beat(mk_beat(OP_REMOVE, 16'h0005, 16'h0003));
    send_beat(mk_beat(OP_ADD,    16'h0001, 16'h0000));
    send_beat(mk_beat(OP_QUERY,  16'h0001, 16'hFFFF));
    send_beat(mk_beat(OP_REMOVE, 16'h0001, 16'h0000));
    send_beat(mk_beat(OP_ADD,    16'hFFFF, 16'hFFFF));
    send_beat(mk_beat(OP_ADD,    16'hFFFF, 16'h0001));
    send_beat(mk_beat(OP_ADD,    16'hFFFF, 16'h0000));
    send_beat(mk_beat(OP_REMOVE, 16'hFFFF, 16'h0001));
    send_beat(mk_beat(OP_REMOVE, 16'hFFFF, 16'hFFFF));
    send_beat(mk_beat(OP_QUERY,  16'hFFFF, 16'h0000));
    send_beat(mk_beat(OP_ADD,    16'h5555, 16'hAAAA));
    send_beat(mk_beat(OP_ADD,    16'hAAAA, 16'h5555));
    send_beat(mk_beat(OP_SPARE,  16'h5555, 16'h1234));
    send_beat(mk_beat(OP_ADD,    16'h0000, 16'h0007));
    send_beat(mk_beat(OP_REMOVE, 16'h0000, 16'h0001));
    send_beat(mk_beat(OP_QUERY,  16'h0000, 16'h0000));
    send_beat(mk_beat(OP_REMOVE, 16'hAAAA, 16'h1000));
    send_beat(mk_beat(OP_REMOVE, 16'h5555, 16'hAAAB));
    send_beat(mk_beat(OP_QUERY,  16'hAAAA, 16'h0000));

    // Random phases: a small key set to hit and saturate, wider sets with heavy
    // adding to fill the table, a draining phase to free slots, then a small set again.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0:       begin pool_size = 8;          add_pct = 45; rem_pct = 30; end
        1:       begin pool_size = 72;         add_pct = 60; rem_pct = 20; end
        2:       begin pool_size = POOL_DEPTH; add_pct = 75; rem_pct = 12; end
        3:       begin pool_size = POOL_DEPTH; add_pct = 35; rem_pct = 50; end
        default: begin pool_size = 12;         add_pct = 50; rem_pct = 30; end
      endcase
      for (int n = 0; n < PHASE_BEATS; n++) send_beat(random_beat(pool_size, add_pct, rem_pct));
    end

    in_valid <= 1'b0;
    while (count_sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (count_sb.errors == 0) begin
      $display("keyed_count_table_core: match");
    end else begin
      $display("keyed_count_table_core: mismatch");
    end
    $finish;
  end

endmodule
